### rtl/core/qrm_pkg.sv
`default_nettype none

package qrm_pkg;

    // Number of matrix entries and quotient width of the divider.
    localparam int NUM_LANES = 9;
    localparam int QUO_W     = 16;
    localparam int NUM_W     = 48;
    localparam int NORM_W    = 33;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Diagonal lanes (r00, r11, r22) carry a Q1.14 scale, the others twice that.
    localparam logic [NUM_LANES-1:0] DIAG_MASK = 9'b100010001;

    // One request on its way through the divider.
    typedef struct packed {
        logic [NUM_LANES-1:0][NUM_W-1:0] rem;
        logic [NUM_LANES-1:0][QUO_W-1:0] quo;
        logic [NUM_LANES-1:0]            neg;
        logic [NORM_W-1:0]               n;
        logic                            zero;
    } qrm_stage_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic empty;
        logic full;
    } qrm_fifo_stat_t;

    // One restoring division step for all lanes: quotient bit b against 2n.
    function automatic qrm_stage_t div_step(qrm_stage_t s, int b);
        qrm_stage_t r;
        logic [NUM_W:0] sh;
        r  = s;
        sh = {15'd0, s.n, 1'b0} << b;
        for (int l = 0; l < NUM_LANES; l++) begin
            if ({1'b0, r.rem[l]} >= sh) begin
                r.rem[l]    = r.rem[l] - sh[NUM_W-1:0];
                r.quo[l][b] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/qrm_fifo.sv
`default_nettype none

module qrm_fifo
    import qrm_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire qrm_stage_t     push_data,
    input  wire logic           pop,
    output qrm_stage_t          head,
    output qrm_fifo_stat_t      stat
);

    qrm_stage_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));

endmodule

`default_nettype wire

### rtl/core/qrm_front.sv
`default_nettype none

module qrm_front
    import qrm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // q_w, q_x, q_y, q_z from bit 0 up
    input  wire qrm_fifo_stat_t stat,
    output logic             push,
    output qrm_stage_t       push_data
);

    logic              adv;
    logic              v1_reg, v2_reg, v3_reg;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    logic signed [33:0] lane_reg [NUM_LANES];
    logic signed [33:0] lane_next [NUM_LANES];
    logic [NORM_W-1:0]  n_reg, n_next;
    qrm_stage_t         out_reg, out_next;
    logic signed [15:0] qw, qx, qy, qz;
    logic [32:0]        mag;

    // The front stalls as a whole only when its last stage cannot enter the queue.
    assign adv      = !(v3_reg && stat.full);
    assign s_tready = adv;
    assign push     = v3_reg && !stat.full;
    assign push_data = out_reg;

    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    // Valid chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one: the ten products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            xw_reg <= qx * qw;
            yw_reg <= qy * qw;
            zw_reg <= qz * qw;
        end
    end

    // Stage two: the norm and the signed numerators of every entry.
    always_comb begin
        n_next = NORM_W'(34'(ww_reg) + 34'(xx_reg) + 34'(yy_reg) + 34'(zz_reg));
        lane_next[0] = 34'(ww_reg) + 34'(xx_reg) - 34'(yy_reg) - 34'(zz_reg);
        lane_next[1] = 34'(xy_reg) - 34'(zw_reg);
        lane_next[2] = 34'(xz_reg) + 34'(yw_reg);
        lane_next[3] = 34'(xy_reg) + 34'(zw_reg);
        lane_next[4] = 34'(ww_reg) + 34'(yy_reg) - 34'(xx_reg) - 34'(zz_reg);
        lane_next[5] = 34'(yz_reg) - 34'(xw_reg);
        lane_next[6] = 34'(xz_reg) - 34'(yw_reg);
        lane_next[7] = 34'(yz_reg) + 34'(xw_reg);
        lane_next[8] = 34'(ww_reg) + 34'(zz_reg) - 34'(xx_reg) - 34'(yy_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg <= n_next;
            for (int l = 0; l < NUM_LANES; l++) begin
                lane_reg[l] <= lane_next[l];
            end
        end
    end

    // Stage three: magnitude, rounding offset and divider start values.
    always_comb begin
        out_next      = '0;
        out_next.n    = n_reg;
        out_next.zero = (n_reg == '0);
        mag           = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            mag             = lane_reg[l][33] ? 33'(-lane_reg[l]) : lane_reg[l][32:0];
            out_next.neg[l] = lane_reg[l][33];
            if (DIAG_MASK[l]) begin
                out_next.rem[l] = ({15'd0, mag} << 15) + {15'd0, n_reg};
            end else begin
                out_next.rem[l] = ({15'd0, mag} << 16) + {15'd0, n_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/qrm_back.sv
`default_nettype none

module qrm_back
    import qrm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire qrm_stage_t   head,
    input  wire qrm_fifo_stat_t stat,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,  // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic              m_tuser   // zero_norm
);

    logic                 adv;
    logic [QUO_W:0]       valid_reg;
    qrm_stage_t           stg_reg [QUO_W+1];
    logic                 out_valid_reg;
    logic [143:0]         data_reg, data_next;
    logic                 zero_reg;
    logic [QUO_W-1:0]     q;

    // The whole divider moves whenever the output register is free or drained.
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && !stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg     <= {valid_reg[QUO_W-1:0], !stat.empty};
            out_valid_reg <= valid_reg[QUO_W];
        end
    end

    // Load from the queue, then one quotient bit per stage, top bit first.
    always_ff @(posedge aclk) begin
        if (adv) begin
            stg_reg[0] <= head;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv) begin
                stg_reg[k+1] <= div_step(stg_reg[k], QUO_W - 1 - k);
            end
        end
    end

    // Sign, saturation and the zero quaternion case.
    always_comb begin
        data_next = '0;
        q         = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            q = stg_reg[QUO_W].quo[l];
            if (stg_reg[QUO_W].zero) begin
                data_next[l*16 +: 16] = '0;
            end else if (stg_reg[QUO_W].neg[l]) begin
                data_next[l*16 +: 16] = (q > 16'd32768) ? 16'h8000 : 16'(-q);
            end else begin
                data_next[l*16 +: 16] = (q > 16'd32767) ? 16'h7fff : q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
            zero_reg <= stg_reg[QUO_W].zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = zero_reg;

endmodule

`default_nettype wire

### rtl/core/quaternion_to_rotation_matrix_unit.sv
// Throughput: one request per cycle, unless m_tready stalls the back and the
// queue fills; three product and sum stages feed a four-entry queue, then
// sixteen restoring divider stages and an output register.
// Reset: synchronous, active low; clears all valid flags and the queue pointers.
`default_nettype none

module quaternion_to_rotation_matrix_unit
    import qrm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,  // q_w, q_x, q_y, q_z from bit 0 up
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,  // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic              m_tuser   // zero_norm
);

    logic            push, pop;
    qrm_stage_t      push_data, head;
    qrm_fifo_stat_t  stat;

    // Front: products, norm, numerators.
    qrm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .stat      (stat),
        .push      (push),
        .push_data (push_data)
    );

    // Queue between the two halves.
    qrm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    // Back: division, rounding and saturation.
    qrm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // A zero quaternion must give an all-zero matrix.
    a_zero_matrix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero quaternion gave non-zero entries");

    // The queue can never be full and empty at once.
    a_fifo_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.full && stat.empty))
        else $error("queue status inconsistent");

    // No push into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !push)
        else $error("push into full queue");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

### tb/tb_quaternion_to_rotation_matrix_unit.sv
`timescale 1ns / 100ps
`default_nettype none

// Expected rotation matrices, one per accepted quaternion, checked in order.
class rotation_scoreboard;
    logic [143:0] mat_q[$];
    logic         zero_q[$];
    int           errors = 0;

    // Round num/den to nearest, ties away from zero, then saturate to Q1.14.
    function automatic logic [15:0] round_entry(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0) begin
            if (q > 32768) q = 32768;
            q = -q;
        end else if (q > 32767) begin
            q = 32767;
        end
        return q[15:0];
    endfunction

    // Work out the matrix for one accepted quaternion and queue it.
    function void note_quaternion(logic [63:0] d);
        longint w, x, y, z, n;
        logic [143:0] m;
        w = longint'($signed(d[15:0]));
        x = longint'($signed(d[31:16]));
        y = longint'($signed(d[47:32]));
        z = longint'($signed(d[63:48]));
        n = w * w + x * x + y * y + z * z;
        m = '0;
        if (n != 0) begin
            m[15:0]    = round_entry(16384 * (n - 2 * (y * y + z * z)), n);
            m[31:16]   = round_entry(32768 * (x * y - z * w), n);
            m[47:32]   = round_entry(32768 * (x * z + y * w), n);
            m[63:48]   = round_entry(32768 * (x * y + z * w), n);
            m[79:64]   = round_entry(16384 * (n - 2 * (x * x + z * z)), n);
            m[95:80]   = round_entry(32768 * (y * z - x * w), n);
            m[111:96]  = round_entry(32768 * (x * z - y * w), n);
            m[127:112] = round_entry(32768 * (y * z + x * w), n);
            m[143:128] = round_entry(16384 * (n - 2 * (x * x + y * y)), n);
        end
        mat_q.push_back(m);
        zero_q.push_back(n == 0);
    endfunction

    // Compare one result with the oldest expected matrix.
    function void check_matrix(logic [143:0] m, logic zn);
        logic [143:0] em;
        logic         ez;
        if (mat_q.size() == 0) begin
            $error("matrix result arrived with none expected");
            errors++;
            return;
        end
        em = mat_q.pop_front();
        ez = zero_q.pop_front();
        for (int k = 0; k < 9; k++) begin
            if (m[k*16 +: 16] !== em[k*16 +: 16]) begin
                $error("r%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                       $signed(em[k*16 +: 16]), $signed(m[k*16 +: 16]));
                errors++;
            end
        end
        if (zn !== ez) begin
            $error("zero_norm: expected %0b, got %0b", ez, zn);
            errors++;
        end
    endfunction

    function int pending();
        return mat_q.size();
    endfunction
endclass

module tb_quaternion_to_rotation_matrix_unit;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY        = 21;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // q_w, q_x, q_y, q_z from bit 0 up
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    logic         m_tuser;   // zero_norm

    rotation_scoreboard matrices = new();
    int  idle_cycles = 0;
    bit  timed_out = 0;
    bit  sending_done = 0;

    quaternion_to_rotation_matrix_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one quaternion and hold it until the block takes it.
    task automatic send_quaternion(logic [15:0] w, logic [15:0] x,
                                   logic [15:0] y, logic [15:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random gap before the next request; valid drops only when a gap is taken.
    task automatic sender_gap(bit gaps_on);
        int g;
        g = gaps_on ? gap_length() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (g) @(negedge aclk);
        end
    endtask

    function automatic logic [15:0] random_component(int mode);
        case (mode)
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 32)) - 16);
            2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Note accepted quaternions and check results; count idle time for the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                matrices.note_quaternion(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                matrices.check_matrix(m_tdata, m_tuser);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (sending_done && matrices.pending() == 0)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver stalls, with calm stretches.
    initial begin
        int g;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
            g = gap_length();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    // Watchdog.
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1'b1;
    end

    // Stimulus.
    initial begin
        logic [15:0] edge_vals [6] = '{16'h0000, 16'h7fff, 16'h8000,
                                      16'h4000, 16'hc000, 16'h0001};
        int mode;
        bit gaps_on;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zero quaternion, identity, axes, extremes and ties.
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'hc000);
        send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quaternion(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_quaternion(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'hffff, 16'h0001, 16'h0000, 16'h0000);
        send_quaternion(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_quaternion(16'h0003, 16'h0001, 16'h0000, 16'h0000);
        sender_gap(1);
        for (int i = 0; i < 12; i++) begin
            send_quaternion(edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)],
                            edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)]);
        end

        // Hold off until the pipeline has drained once.
        s_tvalid <= 1'b0;
        while (matrices.pending() != 0 && !timed_out) @(negedge aclk);
        @(negedge aclk);

        // Random quaternions in bursts, with and without gaps.
        gaps_on = 1'b1;
        for (int i = 0; i < 1100; i++) begin
            if (i % 100 == 0) gaps_on = $urandom_range(0, 2) != 0;
            mode = $urandom_range(0, 9);
            if (mode > 3) mode = 0;
            send_quaternion(random_component(mode), random_component(mode),
                            random_component(mode), random_component(mode));
            sender_gap(gaps_on);
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // End of run.
    initial begin
        wait (aresetn);
        while (!((sending_done && matrices.pending() == 0) || timed_out)) begin
            @(posedge aclk);
        end
        if (!timed_out) begin
            repeat (LATENCY + 10) @(posedge aclk);
        end
        if (!timed_out && matrices.errors == 0 && matrices.pending() == 0) begin
            $display("quaternion_to_rotation_matrix_unit verification clean");
        end else begin
            $display("quaternion_to_rotation_matrix_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
